// ===== rtl/rstoi_pkg.sv =====
// Package for the radix string-to-integer parser.
// Holds the payload structs, the character class codes and the radix limits.
// No dependencies.
`default_nettype none

package rstoi_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned RADIX_W  = 6;
  localparam int unsigned DIGIT_W  = 6;
  localparam int unsigned RESULT_W = 64;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;
  localparam logic [CHAR_W-1:0] LETTER_OFFSET = 8'd10;

  // Character class, decided in the front end
  typedef enum logic [2:0] {
    K_ZERO  = 3'd0,
    K_BLANK = 3'd1,
    K_MINUS = 3'd2,
    K_PLUS  = 3'd3,
    K_DIGIT = 3'd4,
    K_OTHER = 3'd5
  } kind_e;

  typedef struct packed {
    logic [CHAR_W-1:0] char_byte;
    logic              last_char;
  } in_item_t;

  typedef struct packed {
    logic signed [RESULT_W-1:0] parsed_value;
    logic                       parse_status;
  } out_item_t;

  // Classified character as it travels through the queue
  typedef struct packed {
    kind_e              kind;
    logic [DIGIT_W-1:0] digit;
    logic               last;
  } token_t;

endpackage

`default_nettype wire

// ===== rtl/rstoi_front.sv =====
// Front end of the parser: accepts characters and classifies them.
// Depends on rstoi_pkg; feeds rstoi_fifo.
`default_nettype none

module rstoi_front (
  input  wire logic                              push,
  output logic                                   full,
  input  wire rstoi_pkg::in_item_t               in_item_i,
  input  wire logic [rstoi_pkg::RADIX_W-1:0]     radix_i,
  input  wire logic                              q_full_i,
  output logic                                   q_wr_o,
  output rstoi_pkg::token_t                      q_token_o
);
  import rstoi_pkg::*;

  logic [CHAR_W-1:0] c;
  logic [CHAR_W-1:0] dval;
  logic              is_alnum;

  assign c = in_item_i.char_byte;

  // Accept when the queue has room
  assign full   = q_full_i;
  assign q_wr_o = push && !q_full_i;

  // Map the character to a digit value
  always_comb begin
    is_alnum = 1'b1;
    dval     = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      dval = c - CH_ZERO;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      dval = c - CH_LO_A + LETTER_OFFSET;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      dval = c - CH_UP_A + LETTER_OFFSET;
    end else begin
      is_alnum = 1'b0;
    end
  end

  // Classify the character against the radix
  always_comb begin
    q_token_o.digit = dval[DIGIT_W-1:0];
    q_token_o.last  = in_item_i.last_char;
    if (c == CH_NUL) begin
      q_token_o.kind = K_ZERO;
    end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
      q_token_o.kind = K_BLANK;
    end else if (c == CH_MINUS) begin
      q_token_o.kind = K_MINUS;
    end else if (c == CH_PLUS) begin
      q_token_o.kind = K_PLUS;
    end else if (is_alnum && dval[DIGIT_W-1:0] < radix_i) begin
      q_token_o.kind = K_DIGIT;
    end else begin
      q_token_o.kind = K_OTHER;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rstoi_fifo.sv =====
// Short token queue between the front end and the back end.
// Depends on rstoi_pkg for the token type.
`default_nettype none

module rstoi_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_i,
  input  wire rstoi_pkg::token_t wr_data_i,
  output logic                   full_o,
  input  wire logic              rd_i,
  output rstoi_pkg::token_t      rd_data_o,
  output logic                   valid_o
);
  import rstoi_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  token_t            mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  assign full_o    = (cnt_q == CNT_FULL);
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_i && rd_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the written token
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rstoi_back.sv =====
// Back end of the parser: scan state, digit accumulation, result register.
// Depends on rstoi_pkg; reads tokens from rstoi_fifo.
`default_nettype none

module rstoi_back #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [rstoi_pkg::RADIX_W-1:0] radix_i,
  input  wire logic                          tok_valid_i,
  input  wire rstoi_pkg::token_t             tok_i,
  output logic                               tok_pop_o,
  input  wire logic                          pop,
  output logic                               empty,
  output rstoi_pkg::out_item_t               out_item_o
);
  import rstoi_pkg::*;

  typedef enum logic [2:0] {
    PH_SPACE  = 3'b001,
    PH_DIGITS = 3'b010,
    PH_STOP   = 3'b100
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic                   neg_q, neg_d;
  logic                   seen_q, seen_d;
  logic [VALUE_BITS-1:0]  acc_q, acc_d;
  logic [VALUE_BITS-1:0]  acc_step;
  logic [VALUE_BITS-1:0]  mag;
  logic                   res_valid_q;
  out_item_t              res_q;
  logic                   finish;

  // Take a token unless it ends a string and the result slot stays busy
  assign tok_pop_o = tok_valid_i && (!tok_i.last || !res_valid_q || pop);
  assign finish    = tok_pop_o && tok_i.last;

  // One multiply by the radix and add per digit, wrapping
  assign acc_step = acc_q * VALUE_BITS'(radix_i) + VALUE_BITS'(tok_i.digit);

  // Scan state transitions
  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    seen_d  = seen_q;
    acc_d   = acc_q;
    unique case (phase_q)
      PH_SPACE: begin
        case (tok_i.kind)
          K_BLANK: phase_d = PH_SPACE;
          K_MINUS: begin
            neg_d   = 1'b1;
            phase_d = PH_DIGITS;
          end
          K_PLUS:  phase_d = PH_DIGITS;
          K_DIGIT: begin
            acc_d   = acc_step;
            seen_d  = 1'b1;
            phase_d = PH_DIGITS;
          end
          default: phase_d = PH_STOP;
        endcase
      end
      PH_DIGITS: begin
        if (tok_i.kind == K_DIGIT) begin
          acc_d  = acc_step;
          seen_d = 1'b1;
        end else begin
          phase_d = PH_STOP;
        end
      end
      PH_STOP: phase_d = PH_STOP;
      default: phase_d = PH_STOP;
    endcase
  end

  // Apply the sign to the final accumulator, or give zero when no digit was seen
  always_comb begin
    if (!seen_d) begin
      mag = '0;
    end else if (neg_d) begin
      mag = '0 - acc_d;
    end else begin
      mag = acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SPACE;
      neg_q   <= 1'b0;
      seen_q  <= 1'b0;
      acc_q   <= '0;
    end else if (finish) begin
      phase_q <= PH_SPACE;
      neg_q   <= 1'b0;
      seen_q  <= 1'b0;
      acc_q   <= '0;
    end else if (tok_pop_o) begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      seen_q  <= seen_d;
      acc_q   <= acc_d;
    end
  end

  // Hold the result until the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (finish) begin
      res_valid_q <= 1'b1;
    end else if (pop) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      res_q.parsed_value <= RESULT_W'(signed'(mag));
      res_q.parse_status <= !seen_d;
    end
  end

  assign empty      = !res_valid_q;
  assign out_item_o = res_q;

endmodule

`default_nettype wire

// ===== rtl/radix_string_to_int_top.sv =====
// Top level of the radix string-to-integer parser.
// Instantiates rstoi_front, rstoi_fifo and rstoi_back; uses rstoi_pkg.
//
// Usage:
//   Characters enter one byte per transfer on the push/full queue port, with
//   last_char set on the final byte of each string. Every string ending in a
//   marked byte yields one result on the empty/pop port: the signed value
//   wrapped to VALUE_BITS and sign-extended to 64 bits, and parse_status set
//   (value zero) when no digit was found.
//   The radix register is written through cfg_valid_i/cfg_data_i; the user
//   must write it only while the block is idle; the block does not check.
//   cfg_ready_o is always high. Values below 2 act as 2, above 36 as 36.
//   Throughput is one character per cycle while full is low. The token
//   queue registers a character, and the back end then folds it into the
//   accumulator (a VALUE_BITS by 6-bit multiply and add) and, for the last
//   byte of a string, into the result register that the empty/pop port reads.
//   Reset sets the radix to 10, empties the queue and clears the scan state.
//   While a result waits for pop, the next string's last byte waits at the
//   head of the queue; full rises once FIFO_DEPTH - 1 more bytes follow it.
`default_nettype none

module radix_string_to_int_top #(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [rstoi_pkg::RADIX_W-1:0] cfg_data_i,
  input  wire logic                          push,
  output logic                               full,
  input  wire rstoi_pkg::in_item_t           in_item_i,
  output logic                               empty,
  input  wire logic                          pop,
  output rstoi_pkg::out_item_t               out_item_o
);
  import rstoi_pkg::*;

  logic [RADIX_W-1:0] radix_q;
  logic [RADIX_W-1:0] radix_eff;
  logic               q_full;
  logic               q_wr;
  token_t             q_wr_token;
  logic               q_valid;
  token_t             q_rd_token;
  logic               q_rd;

  // Radix register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      radix_q <= cfg_data_i;
    end
  end

  // Clamp the radix to its legal range
  always_comb begin
    if (radix_q < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix_q > RADIX_MAX) begin
      radix_eff = RADIX_MAX;
    end else begin
      radix_eff = radix_q;
    end
  end

  rstoi_front u_front (
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .radix_i   (radix_eff),
    .q_full_i  (q_full),
    .q_wr_o    (q_wr),
    .q_token_o (q_wr_token)
  );

  rstoi_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i (q_wr_token),
    .full_o    (q_full),
    .rd_i      (q_rd),
    .rd_data_o (q_rd_token),
    .valid_o   (q_valid)
  );

  rstoi_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .radix_i     (radix_eff),
    .tok_valid_i (q_valid),
    .tok_i       (q_rd_token),
    .tok_pop_o   (q_rd),
    .pop         (pop),
    .empty       (empty),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTHESIS
  // The back end never reads an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_rd |-> q_valid)
    else $error("token read from empty queue");

  // A failed parse always reports zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.parse_status) |-> (out_item_o.parsed_value == '0))
    else $error("invalid result carries a nonzero value");

  // A waiting result is not dropped before its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result lost without transfer");

  // The clamped radix stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (radix_eff >= RADIX_MIN) && (radix_eff <= RADIX_MAX))
    else $error("radix out of range");
`endif

endmodule

`default_nettype wire
